FILE: design/ssid_pkg.sv
// ---------------------------------------------------------------------------
// ssid_pkg
// Shared constants and types for the sorted set store: capacity, field
// widths, request and status codes, and the command broadcast to the cells.
// ---------------------------------------------------------------------------
package ssid_pkg;

    // storage geometry
    localparam int CAPACITY = 1024;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int MODE_W   = 2;
    localparam int STAT_W   = 3;
    localparam int OCC_W    = 11;

    // or-reduction tree grouping
    localparam int GRP      = 32;
    localparam int NGRP     = (CAPACITY + GRP - 1) / GRP;
    localparam int PAD_W    = NGRP * GRP;

    // request codes
    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUERY  = 2'd2;

    // result status codes
    localparam logic [STAT_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] ST_DUPLICATE = 3'd1;
    localparam logic [STAT_W-1:0] ST_DELETED   = 3'd2;
    localparam logic [STAT_W-1:0] ST_DEL_MISS  = 3'd3;
    localparam logic [STAT_W-1:0] ST_PRESENT   = 3'd4;
    localparam logic [STAT_W-1:0] ST_ABSENT    = 3'd5;
    localparam logic [STAT_W-1:0] ST_FULL      = 3'd6;

    // command broadcast to every cell
    typedef struct packed {
        logic                    cmp;
        logic                    ins;
        logic                    del;
        logic signed [KEY_W-1:0] key;
    } cell_cmd_t;

    // sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CMP   = 5'b00010,
        S_RED1  = 5'b00100,
        S_RED2  = 5'b01000,
        S_APPLY = 5'b10000
    } state_t;

endpackage

FILE: design/ssid_cell.sv
// ---------------------------------------------------------------------------
// ssid_cell
// One slot of the sorted array: holds a key, compares it with the broadcast
// key, and on insert or delete takes its left or right neighbor's key.
// ---------------------------------------------------------------------------
module ssid_cell
    import ssid_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  cell_cmd_t               cmd_i,
    input  logic                    valid_i,
    input  logic                    left_lt_i,
    input  logic signed [KEY_W-1:0] left_entry_i,
    input  logic signed [KEY_W-1:0] right_entry_i,
    output logic signed [KEY_W-1:0] entry_o,
    output logic                    lt_o,
    output logic                    eq_o
);

    logic signed [KEY_W-1:0] entry_reg;
    logic                    lt_reg;
    logic                    eq_reg;

    // compare flags, captured once per request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= 1'b0;
            eq_reg <= 1'b0;
        end else if (cmd_i.cmp) begin
            lt_reg <= valid_i && (entry_reg < cmd_i.key);
            eq_reg <= valid_i && (entry_reg == cmd_i.key);
        end
    end

    // cells at or past the insert point shift right, or left on delete
    always_ff @(posedge aclk) begin
        if (cmd_i.ins && !lt_reg) begin
            entry_reg <= left_lt_i ? cmd_i.key : left_entry_i;
        end else if (cmd_i.del && !lt_reg) begin
            entry_reg <= right_entry_i;
        end
    end

    assign entry_o = entry_reg;
    assign lt_o    = lt_reg;
    assign eq_o    = eq_reg;

endmodule

FILE: design/ssid_or_tree.sv
// ---------------------------------------------------------------------------
// ssid_or_tree
// Two-level registered or-tree over the cells' match flags; the group ors
// and the final or over the groups are each registered.
// ---------------------------------------------------------------------------
module ssid_or_tree
    import ssid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CAPACITY-1:0] eq_i,
    output logic                found_o
);

    logic [PAD_W-1:0] eq_pad;
    logic [NGRP-1:0]  grp_next;
    logic [NGRP-1:0]  grp_reg;
    logic             found_reg;

    assign eq_pad = PAD_W'(eq_i);

    // first level: one or per group of cells
    always_comb begin
        for (int g = 0; g < NGRP; g++) begin
            grp_next[g] = |eq_pad[g*GRP +: GRP];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grp_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            grp_reg   <= grp_next;
            found_reg <= |grp_reg;
        end
    end

    assign found_o = found_reg;

endmodule

FILE: design/sorted_set_insert_delete_member.sv
// ---------------------------------------------------------------------------
// sorted_set_insert_delete_member
// Sorted set of distinct signed 32-bit keys held in a row of compare-and-
// shift cells, with insert, delete and member query requests.
// ---------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready carry one request beat (s_mode, s_value); m_valid/m_ready
//   carry one result beat (m_status, m_occupancy) per request. Mode three is
//   treated as a member query.
//   The key is latched at the accepting edge. The request then passes through
//   the compare step, in which every cell compares against the key, the
//   registered or-tree stages that find an exact match, and the apply step,
//   in which the cells at or past the insert or delete point shift at once
//   and the result is registered. The block then passes through its idle
//   state before it takes the next beat; only one request is in flight at a time.
//   The result sits in an output register; the next request is accepted
//   while it waits, and that request holds before its shift step until the
//   receiver takes the pending result.
//   Reset empties the set (occupancy zero); cell contents are not cleared,
//   only slots below the occupancy count are ever compared.
// ---------------------------------------------------------------------------
module sorted_set_insert_delete_member
    import ssid_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [MODE_W-1:0]       s_mode,
    input  logic signed [KEY_W-1:0] s_value,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [STAT_W-1:0]       m_status,
    output logic [OCC_W-1:0]        m_occupancy
);

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [MODE_W-1:0]       mode_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic                    m_valid_reg, m_valid_next;
    logic [STAT_W-1:0]       status_reg, status_next;
    logic                    found;
    logic                    full;
    logic                    slot_free;
    logic                    do_ins, do_del;
    cell_cmd_t               cmd;

    logic signed [KEY_W-1:0] cell_entry [CAPACITY];
    logic [CAPACITY-1:0]     cell_lt;
    logic [CAPACITY-1:0]     cell_eq;
    logic [CAPACITY-1:0]     cell_valid;

    assign s_ready   = (state_reg == S_IDLE);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign slot_free = !m_valid_reg || m_ready;

    // capture the request beat
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            mode_reg <= s_mode;
            key_reg  <= s_value;
        end
    end

    // decide the result in the apply step
    always_comb begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        count_next  = count_reg;
        status_next = status_reg;
        if (state_reg == S_APPLY && slot_free) begin
            case (mode_reg)
                MODE_INSERT: begin
                    if (found) begin
                        status_next = ST_DUPLICATE;
                    end else if (full) begin
                        status_next = ST_FULL;
                    end else begin
                        status_next = ST_INSERTED;
                        do_ins      = 1'b1;
                        count_next  = count_reg + CNT_W'(1);
                    end
                end
                MODE_DELETE: begin
                    if (found) begin
                        status_next = ST_DELETED;
                        do_del      = 1'b1;
                        count_next  = count_reg - CNT_W'(1);
                    end else begin
                        status_next = ST_DEL_MISS;
                    end
                end
                default: begin
                    status_next = found ? ST_PRESENT : ST_ABSENT;
                end
            endcase
        end
    end

    // sequencer
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_CMP;
            S_CMP:   state_next = S_RED1;
            S_RED1:  state_next = S_RED2;
            S_RED2:  state_next = S_APPLY;
            S_APPLY: begin
                if (slot_free) begin
                    state_next   = S_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_INSERTED;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
        end
    end

    // command broadcast to the cell row
    always_comb begin
        cmd.cmp = (state_reg == S_CMP);
        cmd.ins = do_ins;
        cmd.del = do_del;
        cmd.key = key_reg;
    end

    // row of cells, each linked to its neighbors
    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                    left_lt;
        logic signed [KEY_W-1:0] left_entry;
        logic signed [KEY_W-1:0] right_entry;

        assign cell_valid[i] = (count_reg > CNT_W'(i));

        if (i == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = key_reg;
        end else begin : g_inner
            assign left_lt    = cell_lt[i-1];
            assign left_entry = cell_entry[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            assign right_entry = cell_entry[i];
        end else begin : g_mid
            assign right_entry = cell_entry[i+1];
        end

        ssid_cell u_cell (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .cmd_i         (cmd),
            .valid_i       (cell_valid[i]),
            .left_lt_i     (left_lt),
            .left_entry_i  (left_entry),
            .right_entry_i (right_entry),
            .entry_o       (cell_entry[i]),
            .lt_o          (cell_lt[i]),
            .eq_o          (cell_eq[i])
        );
    end

    // match detection over all cells
    ssid_or_tree u_or_tree (
        .aclk    (aclk),
        .aresetn (aresetn),
        .eq_i    (cell_eq),
        .found_o (found)
    );

    assign m_valid     = m_valid_reg;
    assign m_status    = status_reg;
    assign m_occupancy = OCC_W'(count_reg);

endmodule

FILE: design/ssid_checker.sv
// ---------------------------------------------------------------------------
// ssid_checker
// Port-level checks on the sorted set store, bound to the top level.
// ---------------------------------------------------------------------------
module ssid_checker
    import ssid_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [STAT_W-1:0] m_status,
    input  logic [OCC_W-1:0]  m_occupancy
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_occupancy))
        else $error("result beat changed while stalled");

    // status code in range
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= ST_FULL)
        else $error("status code out of range");

    // full only at capacity
    a_full_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_FULL |-> m_occupancy == OCC_W'(CAPACITY))
        else $error("full reported below capacity");

    // a successful insert or a query hit leaves at least one key
    a_ins_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_INSERTED || m_status == ST_PRESENT)
        |-> m_occupancy != '0)
        else $error("empty set after insert or hit");

endmodule

bind sorted_set_insert_delete_member ssid_checker u_ssid_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_status    (m_status),
    .m_occupancy (m_occupancy)
);
